// ===== rtl/tlca_pkg.sv =====
// Constants, types and command codes for the binary-lifting common-ancestor block.
// Depends on nothing; imported by tree_lca_binary_lifting.
`default_nettype none

package tlca_pkg;

    // Field widths
    localparam int NODE_W      = 10;
    localparam int LEN_W       = 11;
    localparam int DEPTH_W     = 10;

    // Tree geometry
    localparam int NODE_COUNT  = 1024;
    localparam int JUMP_LEVELS = 10;
    localparam int LVL_W       = $clog2(JUMP_LEVELS);
    localparam int TBL_AW      = NODE_W + LVL_W;

    // Saturation limits
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(1023);
    localparam logic [LEN_W-1:0]   DIST_MAX  = LEN_W'(2046);

    // Command codes carried in tuser
    localparam logic [2:0] CMD_ATTACH = 3'd0;
    localparam logic [2:0] CMD_LCA    = 3'd1;
    localparam logic [2:0] CMD_KTH    = 3'd2;
    localparam logic [2:0] CMD_PATH   = 3'd3;
    localparam logic [2:0] CMD_DIST   = 3'd4;

    typedef logic [NODE_W-1:0]  t_node;
    typedef logic [LEN_W-1:0]   t_len;
    typedef logic [DEPTH_W-1:0] t_depth;
    typedef logic [LVL_W-1:0]   t_lvl;

endpackage

`default_nettype wire

// ===== rtl/tree_lca_binary_lifting.sv =====
// Binary-lifting common-ancestor block: sequencer around an ancestor table (two read ports)
// and a depth memory; depends on tlca_pkg. A lift level has a read state and, when its jump is
// taken, a state that takes its output; each descent level has a read and a compare state.
// One item at a time; a new beat is taken the cycle after the result enters the output reg.
// Reset (synchronous, active low) clears sequencer and output valid; memories stay unset.
`default_nettype none

module tree_lca_binary_lifting
    import tlca_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // node_a[9:0], node_b[19:10], steps[30:20]
    input  wire logic [2:0]  i_s_axis_tuser,   // cmd[2:0]
    // result stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata    // node_out[9:0], path_length[20:10]
);

    // Sequencer states
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DA    = 5'd1;
    localparam logic [4:0] S_DB    = 5'd2;
    localparam logic [4:0] S_DX    = 5'd3;
    localparam logic [4:0] S_AT_D  = 5'd4;
    localparam logic [4:0] S_AT_W  = 5'd5;
    localparam logic [4:0] S_AT_R  = 5'd6;
    localparam logic [4:0] S_AT_V  = 5'd7;
    localparam logic [4:0] S_LF_R  = 5'd8;
    localparam logic [4:0] S_LF_V  = 5'd9;
    localparam logic [4:0] S_LC_R  = 5'd10;
    localparam logic [4:0] S_LC_V  = 5'd11;
    localparam logic [4:0] S_LC_F  = 5'd12;
    localparam logic [4:0] S_LC_FV = 5'd13;
    localparam logic [4:0] S_DL_R  = 5'd14;
    localparam logic [4:0] S_DL_V  = 5'd15;
    localparam logic [4:0] S_OUT   = 5'd16;

    // Where a lift continues
    localparam logic RET_OUT = 1'b0;
    localparam logic RET_LCA = 1'b1;

    localparam t_lvl LVL_LAST = LVL_W'(JUMP_LEVELS - 1);
    localparam t_lvl LVL_ONE  = LVL_W'(1);

    // Memories
    t_node  tbl_mem [2**TBL_AW];
    t_depth dep_mem [NODE_COUNT];

    // Control and working registers
    logic [4:0] r_state, n_state;
    logic [2:0] r_cmd,   n_cmd;
    t_node      r_a,     n_a;
    t_node      r_b,     n_b;
    t_len       r_k,     n_k;
    t_depth     r_da,    n_da;
    t_depth     r_db,    n_db;
    t_node      r_x,     n_x;
    t_node      r_y,     n_y;
    t_lvl       r_lvl,   n_lvl;
    t_len       r_lk,    n_lk;
    logic       r_ret,   n_ret;
    t_node      r_res_node, n_res_node;
    t_len       r_res_len,  n_res_len;
    logic       r_out_vld,  n_out_vld;
    t_node      r_out_node, n_out_node;
    t_len       r_out_len,  n_out_len;

    // Memory ports
    logic              tbl_we;
    logic [TBL_AW-1:0] tbl_waddr;
    t_node             tbl_wdata;
    logic [TBL_AW-1:0] tbl_raddr_a, tbl_raddr_b;
    t_node             ta_q, tb_q;
    logic              dep_we;
    t_node             dep_waddr;
    t_depth            dep_wdata;
    t_node             dep_raddr;
    t_depth            dep_q;

    // Datapath helpers
    logic              s_acc;
    t_depth            new_depth;
    t_len              kth_clamp;
    logic signed [12:0] dist_raw;
    t_len              dist_c;
    logic signed [11:0] da_l;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {3'b000, r_out_len, r_out_node};

    // New depth of an attached node
    always_comb begin
        if (r_a == r_b) begin
            new_depth = '0;
        end else if (dep_q == DEPTH_MAX) begin
            new_depth = DEPTH_MAX;
        end else begin
            new_depth = dep_q + DEPTH_W'(1);
        end
    end

    // k clamped to depth of node_a
    assign kth_clamp = (r_k > LEN_W'(r_da)) ? LEN_W'(r_da) : r_k;

    // Distance and climb from a to the common ancestor (dep_q holds its depth)
    assign dist_raw = $signed({3'b000, r_da}) + $signed({3'b000, r_db})
                    - $signed({2'b00, dep_q, 1'b0});
    always_comb begin
        if (dist_raw < 0) begin
            dist_c = '0;
        end else if (dist_raw > $signed({2'b00, DIST_MAX})) begin
            dist_c = DIST_MAX;
        end else begin
            dist_c = dist_raw[LEN_W-1:0];
        end
    end
    assign da_l = $signed({2'b00, r_da}) - $signed({2'b00, dep_q});

    // Memory address selection
    always_comb begin
        tbl_raddr_a = {r_x, r_lvl};
        tbl_raddr_b = {r_y, r_lvl};
        case (r_state)
            S_AT_R:  tbl_raddr_a = {r_x, r_lvl - LVL_ONE};
            S_LC_F:  tbl_raddr_a = {r_x, t_lvl'(0)};
            default: tbl_raddr_a = {r_x, r_lvl};
        endcase
        case (r_state)
            S_DB, S_AT_D: dep_raddr = r_b;
            S_DL_R:       dep_raddr = r_x;
            default:      dep_raddr = r_a;
        endcase
    end

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_a        = r_a;
        n_b        = r_b;
        n_k        = r_k;
        n_da       = r_da;
        n_db       = r_db;
        n_x        = r_x;
        n_y        = r_y;
        n_lvl      = r_lvl;
        n_lk       = r_lk;
        n_ret      = r_ret;
        n_res_node = r_res_node;
        n_res_len  = r_res_len;
        n_out_vld  = r_out_vld && !i_m_axis_tready;
        n_out_node = r_out_node;
        n_out_len  = r_out_len;
        tbl_we     = 1'b0;
        tbl_waddr  = {r_a, r_lvl};
        tbl_wdata  = ta_q;
        dep_we     = 1'b0;
        dep_waddr  = r_a;
        dep_wdata  = new_depth;

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_cmd = i_s_axis_tuser;
                    n_a   = i_s_axis_tdata[9:0];
                    n_b   = i_s_axis_tdata[19:10];
                    n_k   = i_s_axis_tdata[30:20];
                    case (i_s_axis_tuser)
                        CMD_ATTACH: n_state = S_AT_D;
                        CMD_LCA, CMD_KTH, CMD_PATH, CMD_DIST: n_state = S_DA;
                        default: begin
                            n_res_node = i_s_axis_tdata[9:0];
                            n_res_len  = '0;
                            n_state    = S_OUT;
                        end
                    endcase
                end
            end

            // depth reads for queries
            S_DA: n_state = S_DB;
            S_DB: begin
                n_da    = dep_q;
                n_state = S_DX;
            end
            S_DX: begin
                n_db  = dep_q;
                n_lvl = '0;
                if (r_cmd == CMD_KTH) begin
                    n_x       = r_a;
                    n_lk      = kth_clamp;
                    n_res_len = kth_clamp;
                    n_ret     = RET_OUT;
                end else if (r_da < dep_q) begin
                    n_x   = r_b;
                    n_y   = r_a;
                    n_lk  = LEN_W'(dep_q - r_da);
                    n_ret = RET_LCA;
                end else begin
                    n_x   = r_a;
                    n_y   = r_b;
                    n_lk  = LEN_W'(r_da - dep_q);
                    n_ret = RET_LCA;
                end
                n_state = S_LF_R;
            end

            // attach: depth, level 0, then each level from the one below
            S_AT_D: n_state = S_AT_W;
            S_AT_W: begin
                dep_we     = 1'b1;
                tbl_we     = 1'b1;
                tbl_waddr  = {r_a, t_lvl'(0)};
                tbl_wdata  = r_b;
                n_x        = r_b;
                n_lvl      = LVL_ONE;
                n_res_node = r_a;
                n_res_len  = LEN_W'(new_depth);
                n_state    = (JUMP_LEVELS == 1) ? S_OUT : S_AT_R;
            end
            S_AT_R: n_state = S_AT_V;
            S_AT_V: begin
                tbl_we    = 1'b1;
                tbl_waddr = {r_a, r_lvl};
                tbl_wdata = ta_q;
                n_x       = ta_q;
                if (r_lvl == LVL_LAST) begin
                    n_state = S_OUT;
                end else begin
                    n_lvl   = r_lvl + LVL_ONE;
                    n_state = S_AT_R;
                end
            end

            // lift r_x by r_lk, one level per step
            S_LF_R, S_LF_V: begin
                if (r_state == S_LF_R && r_lk[r_lvl]) begin
                    n_state = S_LF_V;
                end else begin
                    if (r_state == S_LF_V) begin
                        n_x = ta_q;
                    end
                    if (r_lvl == LVL_LAST) begin
                        if (r_ret == RET_LCA) begin
                            n_lvl   = LVL_LAST;
                            n_state = S_LC_R;
                        end else begin
                            n_res_node = (r_state == S_LF_V) ? ta_q : r_x;
                            n_state    = S_OUT;
                        end
                    end else begin
                        n_lvl   = r_lvl + LVL_ONE;
                        n_state = S_LF_R;
                    end
                end
            end

            // descent from the top level, both nodes at once
            S_LC_R: n_state = S_LC_V;
            S_LC_V: begin
                if (ta_q != tb_q) begin
                    n_x = ta_q;
                    n_y = tb_q;
                end
                if (r_lvl == '0) begin
                    n_state = S_LC_F;
                end else begin
                    n_lvl   = r_lvl - LVL_ONE;
                    n_state = S_LC_R;
                end
            end
            S_LC_F:  n_state = (r_x != r_y) ? S_LC_FV : S_DL_R;
            S_LC_FV: begin
                n_x     = ta_q;
                n_state = S_DL_R;
            end

            // depth of the common ancestor, then the answer
            S_DL_R: n_state = S_DL_V;
            S_DL_V: begin
                n_res_len = dist_c;
                n_lvl     = '0;
                n_ret     = RET_OUT;
                if (r_cmd != CMD_PATH) begin
                    n_res_node = r_x;
                    n_state    = S_OUT;
                end else if (da_l >= $signed({1'b0, r_k})) begin
                    n_x     = r_a;
                    n_lk    = r_k;
                    n_state = S_LF_R;
                end else if (r_k > dist_c) begin
                    n_res_node = r_b;
                    n_state    = S_OUT;
                end else begin
                    n_x     = r_b;
                    n_lk    = dist_c - r_k;
                    n_state = S_LF_R;
                end
            end

            // hand result to the output register
            S_OUT: begin
                if (!r_out_vld || i_m_axis_tready) begin
                    n_out_vld  = 1'b1;
                    n_out_node = r_res_node;
                    n_out_len  = r_res_len;
                    n_state    = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_a        <= n_a;
        r_b        <= n_b;
        r_k        <= n_k;
        r_da       <= n_da;
        r_db       <= n_db;
        r_x        <= n_x;
        r_y        <= n_y;
        r_lvl      <= n_lvl;
        r_lk       <= n_lk;
        r_ret      <= n_ret;
        r_res_node <= n_res_node;
        r_res_len  <= n_res_len;
        r_out_node <= n_out_node;
        r_out_len  <= n_out_len;
    end

    // Ancestor table: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        ta_q <= tbl_mem[tbl_raddr_a];
        tb_q <= tbl_mem[tbl_raddr_b];
    end

    // Depth memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (dep_we) begin
            dep_mem[dep_waddr] <= dep_wdata;
        end
        dep_q <= dep_mem[dep_raddr];
    end

endmodule

`default_nettype wire
